// File: hw/rtl/lnbgk_pkg.sv
// shared types, widths and helpers for the d2q9 bgk collision node
// depends on nothing; every other rtl file imports it
package lnbgk_pkg;

  localparam int FW         = 20;  // distribution value width, q4.16
  localparam int VW         = 17;  // velocity width, q1.16
  localparam int OW         = 18;  // relaxation rate width, q2.16
  localparam int NDIR       = 9;
  localparam int DW         = 20;  // divider denominator (|rho|)
  localparam int RW         = 22;  // divider partial remainder
  localparam int MW         = 24;  // momentum width
  localparam int MOM_STAGES = 2;
  localparam int DIV_STAGES = VW;
  localparam int COL_STAGES = 9;
  localparam int LAT        = MOM_STAGES + DIV_STAGES + COL_STAGES;

  localparam int DIR_REST = 0;
  localparam int DIR_E    = 1;
  localparam int DIR_N    = 2;
  localparam int DIR_W    = 3;
  localparam int DIR_S    = 4;
  localparam int DIR_NE   = 5;
  localparam int DIR_NW   = 6;
  localparam int DIR_SW   = 7;
  localparam int DIR_SE   = 8;

  localparam logic [VW-1:0] VEL_MAX     = '1;
  localparam logic [OW-1:0] OMEGA_RESET = OW'(65536);
  // ceil(2^33 / 9), exact floor(a/9) for a below 2^33
  localparam logic [29:0]   RECIP9      = 30'd954437177;

  typedef logic signed [FW-1:0] fval_t;
  typedef fval_t [NDIR-1:0] fvec_t;

  typedef struct packed {
    logic zero;  // quotient forced to zero
    logic ovf;   // quotient saturates
  } divflag_t;

  typedef struct packed {
    fvec_t           f;
    fval_t           rho;
    logic [VW-1:0]   ux;
    logic [VW-1:0]   uy;
  } side_t;

  function automatic fval_t sat20(input logic signed [47:0] v);
    fval_t r;
    if (v > 48'sd524287) begin
      r = 20'sh7FFFF;
    end else if (v < -48'sd524288) begin
      r = 20'sh80000;
    end else begin
      r = v[FW-1:0];
    end
    return r;
  endfunction

  // e_i . u for one direction
  function automatic logic signed [18:0] eu_of(input int i, input logic [VW-1:0] ux,
                                               input logic [VW-1:0] uy);
    logic signed [18:0] sx;
    logic signed [18:0] sy;
    logic signed [18:0] r;
    sx = $signed({2'b00, ux});
    sy = $signed({2'b00, uy});
    case (i)
      DIR_E:   r = sx;
      DIR_N:   r = sy;
      DIR_W:   r = -sx;
      DIR_S:   r = -sy;
      DIR_NE:  r = sx + sy;
      DIR_NW:  r = sy - sx;
      DIR_SW:  r = -sx - sy;
      DIR_SE:  r = sx - sy;
      default: r = '0;
    endcase
    return r;
  endfunction

  // weight times 36 is 16, 4 or 1: a left shift
  function automatic logic [2:0] wshift(input int i);
    logic [2:0] r;
    case (i)
      DIR_REST:                    r = 3'd4;
      DIR_E, DIR_N, DIR_W, DIR_S:  r = 3'd2;
      default:                     r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/lnbgk_moments.sv
// density and momentum sums, then divider operand preparation
// two register stages; depends on lnbgk_pkg
module lnbgk_moments (
  input  logic                clk_i,
  input  logic                en_i,
  input  lnbgk_pkg::fvec_t    f_i,
  output lnbgk_pkg::fvec_t    f_o,
  output lnbgk_pkg::fval_t    rho_o,
  output logic [19:0]         den_o,
  output logic [21:0]         numx_o,
  output logic [21:0]         numy_o,
  output lnbgk_pkg::divflag_t flx_o,
  output lnbgk_pkg::divflag_t fly_o
);
  import lnbgk_pkg::*;

  fvec_t                 f_q;
  fval_t                 rho_q;
  logic signed [MW-1:0]  mx_q, my_q;
  logic signed [MW-1:0]  sum_d, mx_d, my_d;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NDIR; i++) begin
      sum_d = sum_d + MW'($signed(f_i[i]));
    end
    mx_d = MW'($signed(f_i[DIR_E])) + MW'($signed(f_i[DIR_NE])) + MW'($signed(f_i[DIR_SE]))
         - MW'($signed(f_i[DIR_W])) - MW'($signed(f_i[DIR_NW])) - MW'($signed(f_i[DIR_SW]));
    my_d = MW'($signed(f_i[DIR_N])) + MW'($signed(f_i[DIR_NE])) + MW'($signed(f_i[DIR_NW]))
         - MW'($signed(f_i[DIR_S])) - MW'($signed(f_i[DIR_SW])) - MW'($signed(f_i[DIR_SE]));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q   <= f_i;
      rho_q <= sat20(48'(sum_d));
      mx_q  <= mx_d;
      my_q  <= my_d;
    end
  end

  logic [DW-1:0]  arho;
  logic [MW-1:0]  amx, amy;
  logic           rneg;
  divflag_t       flx_d, fly_d;

  always_comb begin
    rneg  = rho_q[FW-1];
    arho  = rneg ? DW'(-{rho_q[FW-1], rho_q}) : DW'(rho_q);
    amx   = mx_q[MW-1] ? MW'(-mx_q) : MW'(mx_q);
    amy   = my_q[MW-1] ? MW'(-my_q) : MW'(my_q);
    // negative quotient clamps to zero, so it counts as zero too
    flx_d.zero = (rho_q == '0) || (mx_q == '0) || (mx_q[MW-1] != rneg);
    fly_d.zero = (rho_q == '0) || (my_q == '0) || (my_q[MW-1] != rneg);
    // quotient reaches 2^17 exactly when |m| >= 2|rho|
    flx_d.ovf  = ({1'b0, amx} >= {4'b0, arho, 1'b0});
    fly_d.ovf  = ({1'b0, amy} >= {4'b0, arho, 1'b0});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_o    <= f_q;
      rho_o  <= rho_q;
      den_o  <= arho;
      numx_o <= (flx_d.zero || flx_d.ovf) ? '0 : amx[RW-1:0];
      numy_o <= (fly_d.zero || fly_d.ovf) ? '0 : amy[RW-1:0];
      flx_o  <= flx_d;
      fly_o  <= fly_d;
    end
  end

endmodule

// File: hw/rtl/lnbgk_div.sv
// pipelined restoring divider, one quotient bit per stage, clamped velocity out
// depends on lnbgk_pkg
module lnbgk_div (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [19:0]         den_i,
  input  logic [21:0]         num_i,
  input  lnbgk_pkg::divflag_t fl_i,
  output logic [16:0]         u_o
);
  import lnbgk_pkg::*;

  logic [RW-1:0] rem_q [DIV_STAGES];
  logic [VW-1:0] quo_q [DIV_STAGES];
  logic [DW-1:0] den_q [DIV_STAGES];
  divflag_t      fl_q  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [RW-1:0] rin, rout;
    logic [DW-1:0] din;
    logic [VW-1:0] qin;
    divflag_t      fin;
    logic          qbit;

    if (s == 0) begin : g_first
      assign rin = num_i;
      assign din = den_i;
      assign qin = '0;
      assign fin = fl_i;
    end else begin : g_next
      assign rin = {rem_q[s-1][RW-2:0], 1'b0};
      assign din = den_q[s-1];
      assign qin = quo_q[s-1];
      assign fin = fl_q[s-1];
    end

    assign qbit = (rin >= RW'(din));
    assign rout = qbit ? rin - RW'(din) : rin;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rout;
        quo_q[s] <= {qin[VW-2:0], qbit};
        den_q[s] <= din;
        fl_q[s]  <= fin;
      end
    end
  end

  assign u_o = fl_q[DIV_STAGES-1].zero ? '0 :
               fl_q[DIV_STAGES-1].ovf  ? VEL_MAX : quo_q[DIV_STAGES-1];

endmodule

// File: hw/rtl/lnbgk_collide.sv
// equilibrium and relaxation for the nine directions, nine register stages
// depends on lnbgk_pkg
module lnbgk_collide (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [17:0]      omega_i,
  input  lnbgk_pkg::side_t side_i,
  output lnbgk_pkg::side_t side_o,
  output lnbgk_pkg::fvec_t fnew_o
);
  import lnbgk_pkg::*;

  side_t side_q [COL_STAGES];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < COL_STAGES; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // stage 2: squares
  logic signed [35:0] usq_q;
  logic signed [18:0] eu_q   [NDIR];
  logic signed [37:0] eusq_q [NDIR];
  // stage 3..8 per direction
  logic signed [25:0] poly_q [NDIR];
  logic signed [45:0] x_q    [NDIR];
  logic [30:0]        a_q    [NDIR];
  logic               neg_q  [NDIR];
  logic               neg2_q [NDIR];
  logic [30:0]        a2_q   [NDIR];
  logic [27:0]        qa_q   [NDIR];
  logic signed [29:0] feq_q  [NDIR];
  logic signed [49:0] prod_q [NDIR];

  logic signed [17:0] sux, suy;
  assign sux = $signed({1'b0, side_q[0].ux});
  assign suy = $signed({1'b0, side_q[0].uy});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      usq_q <= 36'(sux * sux) + 36'(suy * suy);
    end
  end

  for (genvar i = 0; i < NDIR; i++) begin : g_dir
    logic signed [18:0] eu;
    logic signed [43:0] twice;
    logic signed [51:0] xs;
    logic signed [33:0] z;
    logic [60:0]        rp;
    logic [30:0]        rem9;
    logic signed [30:0] diff;
    logic signed [33:0] delta;

    assign eu    = eu_of(i, side_q[0].ux, side_q[0].uy);
    // twice the polynomial in q.32
    assign twice = (44'sd1 <<< 33) + 44'(eu_q[i] * 21'sd3) * (44'sd1 <<< 17)
                 + 44'(eusq_q[i]) * 44'sd9 - 44'(usq_q) * 44'sd3;
    assign xs    = 52'(x_q[i]) <<< wshift(i);
    // floor((x + 18*2^16) / 2^18), then floor by 9
    assign z     = 34'((xs + 52'sd1179648) >>> 18);
    assign rp    = 61'(a_q[i]) * 61'(RECIP9);
    assign rem9  = a2_q[i] - 31'(qa_q[i]) * 31'd9;
    assign diff  = 31'(feq_q[i]) - 31'($signed(side_q[6].f[i]));
    assign delta = 34'((prod_q[i] + 50'sd32768) >>> 16);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        eu_q[i]   <= eu;
        eusq_q[i] <= 38'(eu * eu);
        poly_q[i] <= 26'((twice + 44'sd65536) >>> 17);
        x_q[i]    <= 46'(side_q[2].rho * poly_q[i]);
        neg_q[i]  <= z[33];
        a_q[i]    <= z[33] ? 31'(-z) : 31'(z);
        neg2_q[i] <= neg_q[i];
        a2_q[i]   <= a_q[i];
        qa_q[i]   <= rp[60:33];
        feq_q[i]  <= neg2_q[i] ? -30'($signed({2'b00, qa_q[i]})) - 30'(rem9 != '0)
                               : 30'($signed({2'b00, qa_q[i]}));
        prod_q[i] <= 50'($signed({1'b0, omega_i}) * diff);
        fnew_o[i] <= sat20(48'($signed(side_q[7].f[i])) + 48'(delta));
      end
    end
  end

  assign side_o = side_q[COL_STAGES-1];

endmodule

// File: hw/rtl/lattice_node_bgk_collision.sv
// d2q9 bgk collision for one lattice node per beat
// pipeline: 2 sum stages, 17 divider stages (one quotient bit each), 9 collision stages
// throughput one node per cycle; the whole pipeline holds while the output beat waits
// reset clears the stage valid bits and sets the relaxation rate to 1.0; no clearing pass
// depends on lnbgk_pkg, lnbgk_moments, lnbgk_div, lnbgk_collide
module lattice_node_bgk_collision (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [17:0]   cfg_wdata_i,     // relaxation_rate
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // density_rest, _east, _north, _west, _south, _northeast, _northwest, _southwest,
  // _southeast, 20 bits each, zero pad
  input  logic [183:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // new_rest .. new_southeast, node_density (20 bits each), velocity_x, velocity_y
  // (17 bits each), zero pad
  output logic [239:0]  m_axis_tdata
);
  import lnbgk_pkg::*;

  logic [OW-1:0] omega_q;
  logic [LAT-1:0] vld_q;
  logic en;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omega_q <= OMEGA_RESET;
      vld_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        omega_q <= cfg_wdata_i;
      end
      if (en) begin
        vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
      end
    end
  end

  fvec_t    f_in, f_m;
  fval_t    rho_m;
  logic [DW-1:0] den;
  logic [RW-1:0] numx, numy;
  divflag_t flx, fly;
  logic [VW-1:0] ux, uy;

  for (genvar i = 0; i < NDIR; i++) begin : g_unpack
    assign f_in[i] = s_axis_tdata[i*FW +: FW];
  end

  lnbgk_moments u_mom (
    .clk_i  (clk_i),
    .en_i   (en),
    .f_i    (f_in),
    .f_o    (f_m),
    .rho_o  (rho_m),
    .den_o  (den),
    .numx_o (numx),
    .numy_o (numy),
    .flx_o  (flx),
    .fly_o  (fly)
  );

  lnbgk_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .den_i (den),
    .num_i (numx),
    .fl_i  (flx),
    .u_o   (ux)
  );

  lnbgk_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .den_i (den),
    .num_i (numy),
    .fl_i  (fly),
    .u_o   (uy)
  );

  // distributions and density ride alongside the divider
  fvec_t f_dl_q   [DIV_STAGES];
  fval_t rho_dl_q [DIV_STAGES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_dl_q[0]   <= f_m;
      rho_dl_q[0] <= rho_m;
      for (int s = 1; s < DIV_STAGES; s++) begin
        f_dl_q[s]   <= f_dl_q[s-1];
        rho_dl_q[s] <= rho_dl_q[s-1];
      end
    end
  end

  side_t side_in, side_out;
  fvec_t fnew;

  assign side_in.f   = f_dl_q[DIV_STAGES-1];
  assign side_in.rho = rho_dl_q[DIV_STAGES-1];
  assign side_in.ux  = ux;
  assign side_in.uy  = uy;

  lnbgk_collide u_col (
    .clk_i   (clk_i),
    .en_i    (en),
    .omega_i (omega_q),
    .side_i  (side_in),
    .side_o  (side_out),
    .fnew_o  (fnew)
  );

  for (genvar i = 0; i < NDIR; i++) begin : g_pack
    assign m_axis_tdata[i*FW +: FW] = fnew[i];
  end
  assign m_axis_tdata[NDIR*FW +: FW]         = side_out.rho;
  assign m_axis_tdata[(NDIR+1)*FW +: VW]     = side_out.ux;
  assign m_axis_tdata[(NDIR+1)*FW+VW +: VW]  = side_out.uy;
  assign m_axis_tdata[239:(NDIR+1)*FW+2*VW]  = '0;

  // zero density always gives zero velocity
  a_zero_rho : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (side_out.rho == '0) |-> (side_out.ux == '0) && (side_out.uy == '0))
    else $error("nonzero velocity at zero density");

  // an accepted beat enters the first stage
  a_enter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted beat lost at entry");

  // a stalled output freezes the stage valid bits
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(vld_q))
    else $error("pipeline moved during stall");

endmodule
